>>> rtl/core/lambert_conformal_grid_convert_unit_macros.svh
`ifndef LAMBERT_CONFORMAL_GRID_CONVERT_UNIT_MACROS_SVH
`define LAMBERT_CONFORMAL_GRID_CONVERT_UNIT_MACROS_SVH

// Assertion on the block clock, masked while reset is asserted.
`define LCGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication on the block clock, masked while reset is asserted.
`define LCGC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lcgc_pkg.sv
`default_nettype none

package lcgc_pkg;

  // Number formats
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int LOG_FRAC      = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
  localparam int ANG_W         = 34;

  typedef logic signed [ANG_W-1:0] ang_t;

  // Projection constants, Q30 angles and Q20 grid units
  localparam longint SN_Q30   = 64'sd768334045;
  localparam longint K_Q20    = 64'sd2395656697;
  localparam longint RO_Q20   = 64'sd1433170209;
  localparam longint PI4_Q30  = 64'sd843314857;
  localparam longint PI2_Q30  = 64'sd1686629713;
  localparam longint DEG_Q30  = 64'sd18740330;
  localparam longint HDEG_Q30 = 64'sd9370165;

  // Floor square root, two bits per step
  function automatic longint unsigned isq(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned rem;
    r   = 64'd0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC gain An, Q30
  function automatic longint unsigned cordic_gain();
    longint unsigned an;
    longint unsigned f;
    an = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 60) begin
        f = isq((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
      end else begin
        f = 64'd1 << 30;
      end
      an = (an * f) >> 30;
    end
    return an;
  endfunction

  // Inverse CORDIC gain, Q30
  localparam longint unsigned CORDIC_K_RAW = (64'd1 << 60) / cordic_gain();
  localparam ang_t CORDIC_K = ang_t'(CORDIC_K_RAW);

  // Factor 2^(2^-k), Q30
  function automatic longint unsigned ex2_factor(input int k);
    longint unsigned p;
    p = isq(64'd1 << 61);
    for (int j = 1; j < k; j++) begin
      p = isq(p << 30);
    end
    return p;
  endfunction

  // Arctangent of 2^-i, Q30
  function automatic ang_t atan_q30(input int i);
    longint v;
    case (i)
      0:  v = 843314857;
      1:  v = 497837829;
      2:  v = 263043837;
      3:  v = 133525159;
      4:  v = 67021687;
      5:  v = 33543516;
      6:  v = 16775851;
      7:  v = 8388437;
      8:  v = 4194283;
      9:  v = 2097149;
      10: v = 1048576;
      11: v = 524288;
      12: v = 262144;
      13: v = 131072;
      14: v = 65536;
      15: v = 32768;
      16: v = 16384;
      17: v = 8192;
      18: v = 4096;
      19: v = 2048;
      20: v = 1024;
      21: v = 512;
      22: v = 256;
      23: v = 128;
      24: v = 64;
      25: v = 32;
      26: v = 16;
      27: v = 8;
      28: v = 4;
      29: v = 2;
      30: v = 1;
      default: v = 0;
    endcase
    return ang_t'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcgc_cordic.sv
`default_nettype none

module lcgc_cordic
  import lcgc_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  ang_t ang_i,
  output ang_t cos_o,
  output ang_t sin_o
);

  ang_t x_q [CORDIC_STAGES];
  ang_t y_q [CORDIC_STAGES];
  ang_t z_q [CORDIC_STAGES-1];
  ang_t x_in [CORDIC_STAGES];
  ang_t y_in [CORDIC_STAGES];
  ang_t z_in [CORDIC_STAGES];

  // Feed each stage from the one before, the first from the gain-corrected start vector
  always_comb begin
    x_in[0] = CORDIC_K;
    y_in[0] = '0;
    z_in[0] = ang_i;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      x_in[i] = x_q[i-1];
      y_in[i] = y_q[i-1];
      z_in[i] = z_q[i-1];
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    ang_t dx;
    ang_t dy;
    assign dx = y_in[i] >>> i;
    assign dy = x_in[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_in[i] >= 0) begin
          x_q[i] <= x_in[i] - dx;
          y_q[i] <= y_in[i] + dy;
        end else begin
          x_q[i] <= x_in[i] + dx;
          y_q[i] <= y_in[i] - dy;
        end
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_angle
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (z_in[i] >= 0) begin
            z_q[i] <= z_in[i] - atan_q30(i);
          end else begin
            z_q[i] <= z_in[i] + atan_q30(i);
          end
        end
      end
    end
  end

  assign cos_o = x_q[CORDIC_STAGES-1];
  assign sin_o = y_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/lambert_conformal_grid_convert_unit.sv
// Lambert conformal conic grid converter.
// Input channel: in_valid_i / in_stall_o with latitude_i and longitude_i (degrees, 16 fraction
// bits). A request is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with grid_x_o, grid_y_o and range_error_o.
// Configuration: cfg_we_i writes cfg_data_i to grid offset x (index 0) or y (index 1);
// write only while no request is in flight.
// Throughput: one request per cycle while the pipeline is not frozen. Stages, in order:
// input scaling, a CORDIC of one stage per rotation, leading-one detection and normalization,
// one log2 squaring stage per fraction bit, the log clamp and exponent, one 2^f multiply stage
// per fraction bit, the radius, then the grid multiply as low and high partial products and their sum.
// Reset clears all valid bits, the output valid and skid full flags, and loads the offsets 43/136.
// When the receiver stalls, the finished result parks in a skid register; the pipeline
// freezes while the skid register is full, and in_stall_o is driven from that register.
`default_nettype none
`include "lambert_conformal_grid_convert_unit_macros.svh"

module lambert_conformal_grid_convert_unit
  import lcgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] latitude_i,
  input  logic signed [24:0] longitude_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] grid_x_o,
  output logic signed [15:0] grid_y_o,
  output logic               range_error_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  typedef enum logic [0:0] {
    CFG_OFFSET_X = 1'b0,
    CFG_OFFSET_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FOLD_NONE = 2'd0,
    FOLD_POS  = 2'd1,
    FOLD_NEG  = 2'd2
  } fold_e;

  localparam int PIPE_DEPTH = CORDIC_STAGES + 2 * LOG_FRAC + 12;
  localparam int DLY_LEN    = 2 * LOG_FRAC + 5;

  localparam logic signed [23:0] LAT_LIM  = 24'(89 * (1 << FRAC_BITS));
  localparam logic signed [25:0] LON0     = 26'(126 * (1 << FRAC_BITS));
  localparam logic signed [25:0] LON_FULL = 26'(360 * (1 << FRAC_BITS));
  localparam logic signed [25:0] LON_HALF = 26'(180 * (1 << FRAC_BITS));
  localparam logic signed [37:0] L_MAX    = 38'sd8 <<< 30;
  localparam logic signed [48:0] HALF_LSB = 49'sd1 <<< 19;
  localparam logic signed [15:0] SAT_MAX  = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN  = -16'sd32768;
  localparam logic [30:0]        ONE_Q30  = 31'd1 << 30;

  // Upper half of the Q30 square
  function automatic logic [31:0] sq_hi(input logic [30:0] m);
    logic [61:0] p;
    p = 62'(m) * 62'(m);
    return p[61:30];
  endfunction

  // Position of the leading one
  function automatic logic [5:0] lead_pos(input logic [32:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  logic en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic skid_full_q;
  logic out_valid_q;

  logic signed [15:0] off_x_q, off_y_q;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= 16'sd43;
      off_y_q <= 16'sd136;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_OFFSET_X: off_x_q <= cfg_data_i;
        CFG_OFFSET_Y: off_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Stage 1: clamp latitude, form u; wrap longitude difference
  logic signed [23:0] lat_c;
  logic signed [47:0] lat_prod;
  logic signed [25:0] lon_v, lon_m, d_d;
  ang_t u1_q, u2_q, u3_q, u4_q;
  logic signed [25:0] d1_q;

  always_comb begin
    if (latitude_i > LAT_LIM) begin
      lat_c = LAT_LIM;
    end else if (latitude_i < -LAT_LIM) begin
      lat_c = -LAT_LIM;
    end else begin
      lat_c = latitude_i;
    end
    lat_prod = 48'(lat_c) * 48'(HDEG_Q30);

    lon_v = 26'(longitude_i) - LON0;
    if (lon_v <= -LON_FULL) begin
      lon_m = lon_v + LON_FULL;
    end else if (lon_v >= LON_FULL) begin
      lon_m = lon_v - LON_FULL;
    end else begin
      lon_m = lon_v;
    end
    if (lon_m > LON_HALF) begin
      d_d = lon_m - LON_FULL;
    end else if (lon_m < -LON_HALF) begin
      d_d = lon_m + LON_FULL;
    end else begin
      d_d = lon_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= ang_t'(PI4_Q30) + ang_t'(lat_prod >>> FRAC_BITS);
      d1_q <= d_d;
    end
  end

  // Stages 2 and 3: degrees to radians, then scale by the cone constant
  logic signed [55:0] th_prod;
  logic signed [67:0] a_prod;
  ang_t th2_q, a3_q;

  assign th_prod = 56'(d1_q) * 56'(DEG_Q30);
  assign a_prod  = 68'(th2_q) * 68'(SN_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u2_q  <= u1_q;
      th2_q <= ang_t'(th_prod >>> FRAC_BITS);
      u3_q  <= u2_q;
      a3_q  <= ang_t'(a_prod >>> 30);
    end
  end

  // Stage 4: fold the longitude angle into the CORDIC range
  ang_t ang4_q;
  fold_e fold4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u4_q <= u3_q;
      if (a3_q > ang_t'(PI2_Q30)) begin
        ang4_q  <= a3_q - ang_t'(PI2_Q30);
        fold4_q <= FOLD_POS;
      end else if (a3_q < -ang_t'(PI2_Q30)) begin
        ang4_q  <= a3_q + ang_t'(PI2_Q30);
        fold4_q <= FOLD_NEG;
      end else begin
        ang4_q  <= a3_q;
        fold4_q <= FOLD_NONE;
      end
    end
  end

  // Sine and cosine of both angles
  ang_t lat_cos, lat_sin, lon_cos, lon_sin;

  lcgc_cordic u_lat_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (u4_q),
    .cos_o (lat_cos),
    .sin_o (lat_sin)
  );

  lcgc_cordic u_lon_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang4_q),
    .cos_o (lon_cos),
    .sin_o (lon_sin)
  );

  fold_e fold_dly_q [CORDIC_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_dly_q[0] <= fold4_q;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        fold_dly_q[i] <= fold_dly_q[i-1];
      end
    end
  end

  // Log stage 1: clamp to one LSB, find the leading one; unfold longitude results
  ang_t c_cl, s_cl, sa_full, ca_full;
  logic [32:0] cv1_q, sv1_q;
  logic [5:0] pc1_q, ps1_q;
  logic signed [27:0] sa_dly_q [DLY_LEN+1];
  logic signed [27:0] ca_dly_q [DLY_LEN+1];

  always_comb begin
    c_cl = (lat_cos < 1) ? ang_t'(1) : lat_cos;
    s_cl = (lat_sin < 1) ? ang_t'(1) : lat_sin;
    unique case (fold_dly_q[CORDIC_STAGES-1])
      FOLD_POS: begin
        sa_full = lon_cos;
        ca_full = -lon_sin;
      end
      FOLD_NEG: begin
        sa_full = -lon_cos;
        ca_full = lon_sin;
      end
      default: begin
        sa_full = lon_sin;
        ca_full = lon_cos;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cv1_q <= c_cl[32:0];
      sv1_q <= s_cl[32:0];
      pc1_q <= lead_pos(c_cl[32:0]);
      ps1_q <= lead_pos(s_cl[32:0]);
      sa_dly_q[0] <= 28'(sa_full >>> 6);
      ca_dly_q[0] <= 28'(ca_full >>> 6);
      for (int i = 1; i <= DLY_LEN; i++) begin
        sa_dly_q[i] <= sa_dly_q[i-1];
        ca_dly_q[i] <= ca_dly_q[i-1];
      end
    end
  end

  // Log stage 2: normalize mantissas to [1, 2) in Q30
  logic [30:0] ms_q [LOG_FRAC];
  logic [30:0] mc_q [LOG_FRAC];
  logic signed [6:0] ints_q [LOG_FRAC+1];
  logic signed [6:0] intc_q [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] frs_q [1:LOG_FRAC];
  logic [LOG_FRAC-1:0] frc_q [1:LOG_FRAC];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ps1_q >= 6'd30) begin
        ms_q[0] <= 31'(sv1_q >> (ps1_q - 6'd30));
      end else begin
        ms_q[0] <= 31'(sv1_q << (6'd30 - ps1_q));
      end
      if (pc1_q >= 6'd30) begin
        mc_q[0] <= 31'(cv1_q >> (pc1_q - 6'd30));
      end else begin
        mc_q[0] <= 31'(cv1_q << (6'd30 - pc1_q));
      end
      ints_q[0] <= $signed({1'b0, ps1_q}) - 7'sd30;
      intc_q[0] <= $signed({1'b0, pc1_q}) - 7'sd30;
    end
  end

  // Log fraction: one squaring per bit
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    logic [31:0] ts, tc;
    logic [LOG_FRAC-1:0] fs_in, fc_in;

    if (k == 0) begin : g_first
      assign fs_in = '0;
      assign fc_in = '0;
    end else begin : g_rest
      assign fs_in = frs_q[k];
      assign fc_in = frc_q[k];
    end

    assign ts = sq_hi(ms_q[k]);
    assign tc = sq_hi(mc_q[k]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        frs_q[k+1]  <= {fs_in[LOG_FRAC-2:0], ts[31]};
        frc_q[k+1]  <= {fc_in[LOG_FRAC-2:0], tc[31]};
        ints_q[k+1] <= ints_q[k];
        intc_q[k+1] <= intc_q[k];
      end
    end

    if (k < LOG_FRAC - 1) begin : g_mant
      always_ff @(posedge clk_i) begin
        if (en) begin
          ms_q[k+1] <= ts[31] ? ts[31:1] : ts[30:0];
          mc_q[k+1] <= tc[31] ? tc[31:1] : tc[30:0];
        end
      end
    end
  end

  // Log ratio, clamped to +-8
  logic signed [37:0] lg_s, lg_c, l_raw;
  logic signed [34:0] l_q;

  always_comb begin
    lg_s  = (38'(ints_q[LOG_FRAC]) <<< 30) + (38'(frs_q[LOG_FRAC]) << (30 - LOG_FRAC));
    lg_c  = (38'(intc_q[LOG_FRAC]) <<< 30) + (38'(frc_q[LOG_FRAC]) << (30 - LOG_FRAC));
    l_raw = lg_s - lg_c;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (l_raw > L_MAX) begin
        l_q <= 35'(L_MAX);
      end else if (l_raw < -L_MAX) begin
        l_q <= 35'(-L_MAX);
      end else begin
        l_q <= 35'(l_raw);
      end
    end
  end

  // Exponent e = -sn * l, split later into integer and fraction
  logic signed [67:0] e_prod;
  logic signed [33:0] ex_q [LOG_FRAC+1];
  logic [30:0] mx_q [LOG_FRAC+1];

  assign e_prod = 68'(l_q) * 68'(SN_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q[0] <= 34'((-e_prod) >>> 30);
      mx_q[0] <= ONE_Q30;
    end
  end

  // 2^f: one conditional factor per fraction bit
  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_exp
    logic [61:0] mp;
    assign mp = 62'(mx_q[k]) * 62'(ex2_factor(k + 1));

    always_ff @(posedge clk_i) begin
      if (en) begin
        mx_q[k+1] <= ex_q[k][29-k] ? mp[60:30] : mx_q[k];
        ex_q[k+1] <= ex_q[k];
      end
    end
  end

  // Radius: K * 2^f, then shift by the integer exponent
  logic [63:0] k_prod;
  logic [32:0] r0_q;
  logic signed [3:0] n0_q;
  logic [3:0] n_neg;
  logic [40:0] r_q;

  assign k_prod = 64'(K_Q20) * 64'(mx_q[LOG_FRAC]);
  assign n_neg  = 4'(-n0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q <= k_prod[62:30];
      n0_q <= ex_q[LOG_FRAC][33:30];
      if (n0_q >= 0) begin
        r_q <= 41'(r0_q) << n0_q[2:0];
      end else begin
        r_q <= 41'(r0_q) >> n_neg;
      end
    end
  end

  // Grid multiply, low and high partial products
  logic signed [49:0] pxl_q, pxh_q, pyl_q, pyh_q;
  logic signed [27:0] sa_t, ca_t;

  assign sa_t = sa_dly_q[DLY_LEN];
  assign ca_t = ca_dly_q[DLY_LEN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q <= 50'($signed({1'b0, r_q[20:0]})) * 50'(sa_t);
      pxh_q <= 50'($signed({1'b0, r_q[40:21]})) * 50'(sa_t);
      pyl_q <= 50'($signed({1'b0, r_q[20:0]})) * 50'(ca_t);
      pyh_q <= 50'($signed({1'b0, r_q[40:21]})) * 50'(ca_t);
    end
  end

  // Sum partial products back to Q20
  logic signed [71:0] fx, fy;
  logic signed [47:0] x_q, y_q;

  assign fx = (72'(pxh_q) <<< 21) + 72'(pxl_q);
  assign fy = (72'(pyh_q) <<< 21) + 72'(pyl_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= 48'(fx >>> 24);
      y_q <= 48'(RO_Q20) - 48'(fy >>> 24);
    end
  end

  // Offset, round half up, saturate
  logic signed [48:0] sx, sy;
  logic signed [28:0] gx_full, gy_full;
  logic signed [15:0] res_x, res_y;
  logic res_err;

  always_comb begin
    sx      = 49'(x_q) + (49'(off_x_q) <<< 20) + HALF_LSB;
    sy      = 49'(y_q) + (49'(off_y_q) <<< 20) + HALF_LSB;
    gx_full = 29'(sx >>> 20);
    gy_full = 29'(sy >>> 20);
    res_err = 1'b0;
    if (gx_full > 29'(SAT_MAX)) begin
      res_x   = SAT_MAX;
      res_err = 1'b1;
    end else if (gx_full < 29'(SAT_MIN)) begin
      res_x   = SAT_MIN;
      res_err = 1'b1;
    end else begin
      res_x = 16'(gx_full);
    end
    if (gy_full > 29'(SAT_MAX)) begin
      res_y   = SAT_MAX;
      res_err = 1'b1;
    end else if (gy_full < 29'(SAT_MIN)) begin
      res_y   = SAT_MIN;
      res_err = 1'b1;
    end else begin
      res_y = 16'(gy_full);
    end
  end

  // Output register and skid register
  logic last_v;
  logic signed [15:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic out_err_q, skid_err_q;

  assign last_v = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end
    end else if (last_v) begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (!out_stall_i) begin
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
        out_err_q <= skid_err_q;
      end
    end else if (last_v) begin
      if (!out_valid_q || !out_stall_i) begin
        out_x_q   <= res_x;
        out_y_q   <= res_y;
        out_err_q <= res_err;
      end else begin
        skid_x_q   <= res_x;
        skid_y_q   <= res_y;
        skid_err_q <= res_err;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign grid_x_o      = out_x_q;
  assign grid_y_o      = out_y_q;
  assign range_error_o = out_err_q;

  `LCGC_ASSERT_IMPL(a_skid_behind_out, skid_full_q, out_valid_q, "skid full without output")
  `LCGC_ASSERT(a_skid_fill, out_valid_q && out_stall_i && !skid_full_q && vld_q[PIPE_DEPTH-1] |=> skid_full_q, "stalled result not parked")
  `LCGC_ASSERT(a_skid_drain, skid_full_q && !out_stall_i |=> !skid_full_q && out_valid_q, "skid did not drain")
  `LCGC_ASSERT_IMPL(a_err_sat, out_valid_q && out_err_q, out_x_q == SAT_MAX || out_x_q == SAT_MIN || out_y_q == SAT_MAX || out_y_q == SAT_MIN, "range error without saturation")

endmodule

`default_nettype wire

>>> verif/tb_lambert_conformal_grid_convert_unit.sv
`default_nettype none

// Expected grid cells for accepted coordinate requests, with a bit-exact
// fixed-point projection of each request.
class grid_cell_scoreboard;
  typedef struct {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic               err;
  } grid_cell_t;

  grid_cell_t pending_cells[$];
  longint     offset_x;
  longint     offset_y;
  longint     cordic_gain_inv;
  longint     atan_lut[24];
  int         mismatches;
  int         requests_noted;

  function new();
    longint unsigned an;
    offset_x       = 43;
    offset_y       = 136;
    mismatches     = 0;
    requests_noted = 0;
    atan_lut = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    // Product of floor square roots of 1 + 4^-i, Q30
    an = 64'd1 << 30;
    for (int i = 0; i < 24; i++) begin
      an = (an * sqrt_floor((64'd1 << 60) + (64'd1 << (60 - 2 * i)))) >> 30;
    end
    cordic_gain_inv = longint'((64'd1 << 60) / an);
  endfunction

  function longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Rotate (1/An, 0) by ang, Q30
  function void rotate(input longint ang, output longint cs, output longint sn);
    longint x;
    longint y;
    longint z;
    longint nx;
    x = cordic_gain_inv;
    y = 0;
    z = ang;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_lut[i];
      end
      x = nx;
    end
    cs = x;
    sn = y;
  endfunction

  function longint log2_q30(longint v);
    longint unsigned t;
    longint unsigned m;
    longint          res;
    int              p;
    t = v;
    p = 0;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    m   = (p >= 30) ? (longint'(v) >> (p - 30)) : (longint'(v) << (30 - p));
    res = longint'(p - 30) * (64'sd1 << 30);
    for (int k = 1; k <= 24; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m   = m >> 1;
        res = res + (64'sd1 << (30 - k));
      end
    end
    return res;
  endfunction

  function longint unsigned exp2_frac(longint f);
    longint unsigned m;
    longint unsigned p;
    m = 64'd1 << 30;
    p = sqrt_floor(64'd1 << 61);
    for (int k = 1; k <= 24; k++) begin
      if ((f >> (30 - k)) & 1) m = (m * p) >> 30;
      p = sqrt_floor(p << 30);
    end
    return m;
  endfunction

  function logic signed [15:0] saturate(longint v, inout logic err);
    if (v > 32767) begin
      err = 1'b1;
      return 16'sd32767;
    end
    if (v < -32768) begin
      err = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function grid_cell_t project(logic signed [23:0] lat_in, logic signed [24:0] lon_in);
    grid_cell_t proj;
    longint lat, lon, lim, u, c, s, l, e, n, f, r, d, th, a, ca, sa, tc, ts, x, y;
    longint unsigned ru;
    logic err;
    lat = lat_in;
    lon = lon_in;
    lim = 89 * 65536;
    err = 1'b0;
    if (lat > lim) lat = lim;
    if (lat < -lim) lat = -lim;
    // Radius from tan(pi/4 + lat/2)^-sn via log2/exp2
    u = 64'sd843314857 + ((lat * 64'sd9370165) >>> 16);
    rotate(u, c, s);
    if (c < 1) c = 1;
    if (s < 1) s = 1;
    l = log2_q30(s) - log2_q30(c);
    if (l > 8 * (64'sd1 << 30)) l = 8 * (64'sd1 << 30);
    if (l < -8 * (64'sd1 << 30)) l = -8 * (64'sd1 << 30);
    e  = (-(64'sd768334045 * l)) >>> 30;
    n  = e >>> 30;
    f  = e - n * (64'sd1 << 30);
    ru = (64'd2395656697 * exp2_frac(f)) >> 30;
    r  = longint'(ru);
    if (n > 8) n = 8;
    if (n < -40) n = -40;
    if (n >= 0) r = r << n;
    else r = r >>> (-n);
    // Wrapped longitude difference scaled by the cone factor
    d = (lon - 126 * 65536) % (360 * 65536);
    if (d > 180 * 65536) d = d - 360 * 65536;
    if (d < -180 * 65536) d = d + 360 * 65536;
    th = (d * 64'sd18740330) >>> 16;
    a  = (th * 64'sd768334045) >>> 30;
    if (a > 64'sd1686629713) begin
      rotate(a - 64'sd1686629713, tc, ts);
      sa = tc;
      ca = -ts;
    end else if (a < -64'sd1686629713) begin
      rotate(a + 64'sd1686629713, tc, ts);
      sa = -tc;
      ca = ts;
    end else begin
      rotate(a, ca, sa);
    end
    x = (r * (sa >>> 6)) >>> 24;
    y = 64'sd1433170209 - ((r * (ca >>> 6)) >>> 24);
    proj.gx  = saturate((x + offset_x * (64'sd1 << 20) + (64'sd1 << 19)) >>> 20, err);
    proj.gy  = saturate((y + offset_y * (64'sd1 << 20) + (64'sd1 << 19)) >>> 20, err);
    proj.err = err;
    return proj;
  endfunction

  function void note_request(logic signed [23:0] lat, logic signed [24:0] lon);
    pending_cells.push_back(project(lat, lon));
    requests_noted++;
  endfunction

  function void check_cell(logic signed [15:0] gx, logic signed [15:0] gy, logic err);
    grid_cell_t want;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result x=%0d y=%0d err=%0b", gx, gy, err);
      return;
    end
    want = pending_cells.pop_front();
    if (want.gx !== gx || want.gy !== gy || want.err !== err) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                 want.gx, want.gy, want.err, gx, gy, err);
    end
  endfunction
endclass

module tb_lambert_conformal_grid_convert_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CFG_OFFSET_X = 0;
  localparam int         CFG_OFFSET_Y = 1;
  localparam int         SETTLE_CYCLES = 120;
  localparam longint     CYCLE_LIMIT = 600000;
  localparam logic signed [23:0] LAT_MAX = 24'sd5832704;
  localparam logic signed [24:0] LON_MAX = 25'sd11796480;
  localparam logic signed [24:0] LON_ORIGIN = 25'sd8257536;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] latitude_i = '0;
  logic signed [24:0] longitude_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] grid_x_o;
  logic signed [15:0] grid_y_o;
  logic               range_error_o;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  grid_cell_scoreboard cells = new();
  longint cycle_count = 0;

  lambert_conformal_grid_convert_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one request and hold it until taken
  task automatic send_request(logic signed [23:0] lat, logic signed [24:0] lon);
    in_valid_i  <= 1'b1;
    latitude_i  <= lat;
    longitude_i <= lon;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    cells.note_request(lat, lon);
  endtask

  task automatic go_idle(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain the pipeline, then write both offsets
  task automatic write_offsets(logic signed [15:0] ox, logic signed [15:0] oy);
    go_idle(1);
    while (cells.pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= 1'(CFG_OFFSET_X);
    cfg_data_i  <= ox;
    @(posedge clk_i);
    cfg_index_i <= 1'(CFG_OFFSET_Y);
    cfg_data_i  <= oy;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cells.offset_x = ox;
    cells.offset_y = oy;
    @(posedge clk_i);
  endtask

  // Mostly in-range coordinates, some raw bit patterns
  task automatic random_bursts(int count);
    int burst_len;
    int sent;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
    sent = 0;
    while (sent < count) begin
      burst_len = $urandom_range(1, 24);
      for (int i = 0; i < burst_len && sent < count; i++) begin
        lat = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                          : 24'($urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
        lon = ($urandom_range(0, 9) == 0) ? 25'($urandom)
                                          : 25'($urandom_range(0, 2 * LON_MAX) - LON_MAX);
        send_request(lat, lon);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 10));
    end
  endtask

  // Receiver stall pattern with one long hold-off
  initial begin
    int hold_left;
    int mode;
    bit long_done;
    hold_left = 0;
    long_done = 0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      if (cycle_count % 80 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_done && cells.requests_noted >= 400) begin
        long_done = 1;
        hold_left = 400;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= cycle_count[0];
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // Check each taken result
  initial begin
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic               err;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        gx  = grid_x_o;
        gy  = grid_y_o;
        err = range_error_o;
        @(posedge clk_i);
        cells.check_cell(gx, gy, err);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, clamping, wrapping and quarter-turn folding
    send_request(0, LON_ORIGIN);
    send_request(LAT_MAX, LON_ORIGIN);
    send_request(-LAT_MAX, LON_ORIGIN);
    send_request(24'sh7FFFFF, 0);
    send_request(24'sh800000, 0);
    send_request(24'sh000001, 25'sh0000001);
    send_request(24'shFFFFFF, 25'sh1FFFFFF);
    send_request(24'sd2490368, LON_MAX);
    send_request(24'sd2490368, -LON_MAX);
    send_request(24'sd2490368, 25'shFFFFFF);
    send_request(24'sd2490368, 25'sh1000000);
    send_request(24'sd2490368, LON_ORIGIN + 25'sd11796480);
    send_request(24'sd2490368, LON_ORIGIN - 25'sd11796480);
    send_request(24'sd2490368, -25'sd2883584);
    send_request(24'sd2490368, 25'sd16000000);
    send_request(24'sd1000, 25'sd8000000);
    send_request(-24'sd5000000, 25'sd9000000);
    send_request(24'sd5800000, -25'sd9000000);
    send_request(-LAT_MAX, 25'sd200000);

    write_offsets(0, 0);
    random_bursts(600);
    write_offsets(16'sh7FFF, 16'sh8000);
    random_bursts(400);
    write_offsets(16'sh8000, 16'sh7FFF);
    random_bursts(400);
    write_offsets(16'($urandom), 16'($urandom));
    random_bursts(480);

    go_idle(1);
    while (cells.pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (cells.mismatches == 0 && cells.pending_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> lambert_conformal_grid_convert_unit.f
+incdir+rtl/core
rtl/core/lcgc_pkg.sv
rtl/core/lcgc_cordic.sv
rtl/core/lambert_conformal_grid_convert_unit.sv
verif/tb_lambert_conformal_grid_convert_unit.sv
